// ----- rtl/page_cache_tag_directory_macros.svh -----
// ----------------------------------------------------------------------------
// page cache tag directory assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PAGE_CACHE_TAG_DIRECTORY_MACROS_SVH
`define PAGE_CACHE_TAG_DIRECTORY_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PCTD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PCTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pctd_pkg.sv -----
// ----------------------------------------------------------------------------
// pctd_pkg
// shared widths, codes and controller interface types of the tag directory
// ----------------------------------------------------------------------------
package pctd_pkg;

	localparam int SLOT_COUNT_DEF = 32;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam int ID_W       = 32;
	localparam int OFF_W      = 32;
	localparam int SLOT_IDX_W = 5;
	localparam int IN_PAGE_W  = 12;
	localparam int REFS_W     = 16;

	localparam logic [REFS_W-1:0] REFS_MAX = '1;

	localparam logic OP_READ   = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef struct packed {
		logic load;
		logic scan;
		logic write;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_end;
	} ctrl_stat_t;

endpackage

// ----- rtl/pctd_ram.sv -----
// ----------------------------------------------------------------------------
// pctd_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pctd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/pctd_ctrl.sv -----
// ----------------------------------------------------------------------------
// pctd_ctrl
// sequencer: load request, scan the tag ram, write back, hand off the result
// ----------------------------------------------------------------------------
module pctd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  pctd_pkg::ctrl_stat_t  stat,
	output pctd_pkg::ctrl_cmd_t   cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_WRITE  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_end) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = ST_FINISH;
			end
			ST_FINISH: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/pctd_dp.sv -----
// ----------------------------------------------------------------------------
// pctd_dp
// request registers, tag ram scan and compare, replacement pointer, results
// ----------------------------------------------------------------------------
module pctd_dp #(
	parameter int SLOT_COUNT = pctd_pkg::SLOT_COUNT_DEF,
	parameter int PAGE_BYTES = pctd_pkg::PAGE_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pctd_pkg::ctrl_cmd_t               cmd,
	output pctd_pkg::ctrl_stat_t              stat,
	input  logic                              operation,
	input  logic [pctd_pkg::ID_W-1:0]         device_id,
	input  logic [pctd_pkg::ID_W-1:0]         inode_number,
	input  logic [pctd_pkg::OFF_W-1:0]        byte_offset,
	output logic                              hit,
	output logic                              allocated,
	output logic [pctd_pkg::SLOT_IDX_W-1:0]   slot_index,
	output logic [pctd_pkg::OFF_W-1:0]        page_base,
	output logic [pctd_pkg::IN_PAGE_W-1:0]    in_page_offset,
	output logic [pctd_pkg::REFS_W-1:0]       reference_count
);

	localparam int ID_W    = pctd_pkg::ID_W;
	localparam int OFF_W   = pctd_pkg::OFF_W;
	localparam int SIW     = pctd_pkg::SLOT_IDX_W;
	localparam int IPW     = pctd_pkg::IN_PAGE_W;
	localparam int REFS_W  = pctd_pkg::REFS_W;
	localparam int IDX_W   = $clog2(SLOT_COUNT);
	localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
	localparam int PG_SH   = $clog2(PAGE_BYTES);
	localparam int PG_W    = OFF_W - PG_SH;
	localparam int ENTRY_W = 2 * ID_W + PG_W + REFS_W;

	localparam logic [OFF_W-1:0]  PAGE_MASK = OFF_W'(PAGE_BYTES - 1);
	localparam logic [REFS_W-1:0] REFS_ONE  = REFS_W'(1);

	// request
	logic             op_q;
	logic [ID_W-1:0]  dev_q;
	logic [ID_W-1:0]  ino_q;
	logic [OFF_W-1:0] off_q;
	logic [PG_W-1:0]  page_tag;

	// scan
	logic [CNT_W-1:0] scan_cnt_q;
	logic             vld_s1;
	logic [IDX_W-1:0] addr_s1;
	logic             rd_en;
	logic [ENTRY_W-1:0] rd_data;
	logic             match;
	logic             exhausted;

	// replacement
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] victim_q;

	// lookup outcome
	logic              found_q;
	logic [IDX_W-1:0]  found_slot_q;
	logic [REFS_W-1:0] found_refs_q;
	logic [REFS_W-1:0] refs_inc;
	logic              do_alloc;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	logic              res_hit_q;
	logic              res_alloc_q;
	logic [IDX_W-1:0]  res_slot_q;
	logic [REFS_W-1:0] res_refs_q;

	logic              hit_q;
	logic              alloc_q;
	logic [SIW-1:0]    slot_q;
	logic [OFF_W-1:0]  base_q;
	logic [IPW-1:0]    within_q;
	logic [REFS_W-1:0] refs_q;

	assign page_tag = off_q[OFF_W-1:PG_SH];

	// one entry issued per cycle, compared in the cycle after it is issued
	assign rd_en     = cmd.scan && (scan_cnt_q < fill_q);
	assign match     = vld_s1
		&& (rd_data[ENTRY_W-1 -: ID_W] == dev_q)
		&& (rd_data[ENTRY_W-ID_W-1 -: ID_W] == ino_q)
		&& (rd_data[REFS_W +: PG_W] == page_tag);
	assign exhausted = !vld_s1 && (scan_cnt_q >= fill_q);

	assign stat.scan_end = match || exhausted;

	assign refs_inc = (found_refs_q == pctd_pkg::REFS_MAX) ? found_refs_q
		: found_refs_q + REFS_ONE;
	assign do_alloc = !found_q && (op_q == pctd_pkg::OP_READ);

	assign wr_en   = cmd.write && (op_q == pctd_pkg::OP_READ);
	assign wr_addr = found_q ? found_slot_q : victim_q;
	assign wr_data = {dev_q, ino_q, page_tag, found_q ? refs_inc : REFS_ONE};

	pctd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_cnt_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			vld_s1     <= 1'b0;
			fill_q     <= '0;
			victim_q   <= '0;
		end else begin
			if (cmd.load) begin
				scan_cnt_q <= '0;
				vld_s1     <= 1'b0;
			end else if (cmd.scan) begin
				vld_s1 <= rd_en;
				if (rd_en) begin
					scan_cnt_q <= scan_cnt_q + CNT_W'(1);
				end
			end
			// slots fill in order, so the fill count doubles as the valid map
			if (cmd.write && do_alloc) begin
				victim_q <= (victim_q == IDX_W'(SLOT_COUNT - 1)) ? '0
					: victim_q + IDX_W'(1);
				if (fill_q != CNT_W'(SLOT_COUNT)) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			dev_q <= device_id;
			ino_q <= inode_number;
			off_q <= byte_offset;
		end
		if (cmd.scan && rd_en) begin
			addr_s1 <= scan_cnt_q[IDX_W-1:0];
		end
		if (cmd.scan && stat.scan_end) begin
			found_q      <= match;
			found_slot_q <= addr_s1;
			found_refs_q <= rd_data[REFS_W-1:0];
		end
		if (cmd.write) begin
			res_hit_q   <= found_q;
			res_alloc_q <= do_alloc;
			if (found_q) begin
				res_slot_q <= found_slot_q;
				res_refs_q <= (op_q == pctd_pkg::OP_READ) ? refs_inc : found_refs_q;
			end else if (do_alloc) begin
				res_slot_q <= victim_q;
				res_refs_q <= REFS_ONE;
			end else begin
				res_slot_q <= '0;
				res_refs_q <= '0;
			end
		end
		if (cmd.out_load) begin
			hit_q    <= res_hit_q;
			alloc_q  <= res_alloc_q;
			slot_q   <= SIW'(res_slot_q);
			base_q   <= off_q & ~PAGE_MASK;
			within_q <= IPW'(off_q & PAGE_MASK);
			refs_q   <= res_refs_q;
		end
	end

	assign hit             = hit_q;
	assign allocated       = alloc_q;
	assign slot_index      = slot_q;
	assign page_base       = base_q;
	assign in_page_offset  = within_q;
	assign reference_count = refs_q;

endmodule

// ----- rtl/page_cache_tag_directory.sv -----
// ----------------------------------------------------------------------------
// page_cache_tag_directory
// tag directory of a fully associative page cache with round-robin refill
// ----------------------------------------------------------------------------
// channel   dir   handshake            word
// request   in    in_valid/in_ready    operation, device_id, inode_number,
//                                      byte_offset
// result    out   out_valid/out_ready  hit, allocated, slot_index, page_base,
//                                      in_page_offset, reference_count
//
// a request reads the filled slots in order up to the hit (all filled slots
// on a miss, at most SLOT_COUNT, none on an empty directory): the tag ram
// yields one entry per cycle.
// reset clears the controller, the fill count and the refill pointer; the
// tag ram needs no clearing pass, slots at or above the fill count are empty.
// a held result does not block acceptance; the next result waits for it.
// ----------------------------------------------------------------------------
`include "page_cache_tag_directory_macros.svh"

module page_cache_tag_directory #(
	parameter int SLOT_COUNT = pctd_pkg::SLOT_COUNT_DEF,
	parameter int PAGE_BYTES = pctd_pkg::PAGE_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [pctd_pkg::ID_W-1:0]         device_id,
	input  logic [pctd_pkg::ID_W-1:0]         inode_number,
	input  logic [pctd_pkg::OFF_W-1:0]        byte_offset,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic                              allocated,
	output logic [pctd_pkg::SLOT_IDX_W-1:0]   slot_index,
	output logic [pctd_pkg::OFF_W-1:0]        page_base,
	output logic [pctd_pkg::IN_PAGE_W-1:0]    in_page_offset,
	output logic [pctd_pkg::REFS_W-1:0]       reference_count
);

	pctd_pkg::ctrl_cmd_t  cmd;
	pctd_pkg::ctrl_stat_t stat;

	pctd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pctd_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.operation       (operation),
		.device_id       (device_id),
		.inode_number    (inode_number),
		.byte_offset     (byte_offset),
		.hit             (hit),
		.allocated       (allocated),
		.slot_index      (slot_index),
		.page_base       (page_base),
		.in_page_offset  (in_page_offset),
		.reference_count (reference_count)
	);

	`PCTD_ASSERT_NOW(a_alloc_fresh, out_valid && allocated, !hit && reference_count == 16'd1, "allocated slot must be a miss with one reference")

	`PCTD_ASSERT_NOW(a_miss_empty, out_valid && !hit && !allocated, slot_index == '0 && reference_count == 16'd0, "lookup miss must report slot zero and no references")

	`PCTD_ASSERT_NOW(a_hit_refs, out_valid && hit, reference_count != 16'd0, "hit slot must hold at least one reference")

	`PCTD_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "request accepted while one is in flight")

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the page cache tag directory: lookup words are
// queued up front and driven with random gaps against a stalling receiver;
// each result word is checked against a behavioural copy of the directory
// ----------------------------------------------------------------------------
module tb_top;
	import pctd_pkg::*;

	localparam int SLOTS         = SLOT_COUNT_DEF;
	localparam int PAGE_SHIFT    = IN_PAGE_W;
	localparam int PAGE_W        = OFF_W - PAGE_SHIFT;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 2 * (SLOTS + 4);
	localparam int MAX_REPORTS   = 100;
	localparam int RANDOM_WORDS  = 750;
	localparam int SAT_HITS      = 8;

	typedef struct {
		logic             op;
		logic [ID_W-1:0]  dev;
		logic [ID_W-1:0]  ino;
		logic [OFF_W-1:0] off;
		int               idle_before;
		bit               drain;
		bit               rx_stall;
	} lookup_req_t;

	typedef struct {
		logic                  hit;
		logic                  allocated;
		logic [SLOT_IDX_W-1:0] slot;
		logic [OFF_W-1:0]      base;
		logic [IN_PAGE_W-1:0]  in_page;
		logic [REFS_W-1:0]     refs;
	} lookup_res_t;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  in_valid       = 1'b0;
	logic                  in_ready;
	logic                  operation      = OP_READ;
	logic [ID_W-1:0]       device_id      = '0;
	logic [ID_W-1:0]       inode_number   = '0;
	logic [OFF_W-1:0]      byte_offset    = '0;
	logic                  out_valid;
	logic                  out_ready      = 1'b0;
	logic                  hit;
	logic                  allocated;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic [OFF_W-1:0]      page_base;
	logic [IN_PAGE_W-1:0]  in_page_offset;
	logic [REFS_W-1:0]     reference_count;

	// bench copy of the directory
	bit                slot_used   [SLOTS];
	logic [ID_W-1:0]   slot_dev    [SLOTS];
	logic [ID_W-1:0]   slot_ino    [SLOTS];
	logic [PAGE_W-1:0] slot_page   [SLOTS];
	logic [REFS_W-1:0] slot_refcnt [SLOTS];
	int                refill_ptr = 0;

	lookup_req_t lookup_queue[$];
	lookup_res_t expected_lookups[$];

	int mismatches = 0;
	int quiet      = 0;
	int idle_left  = 0;
	int stall_left = 0;
	bit req_taken  = 1'b0;
	bit rx_stall_on = 1'b1;

	page_cache_tag_directory dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.device_id       (device_id),
		.inode_number    (inode_number),
		.byte_offset     (byte_offset),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.hit             (hit),
		.allocated       (allocated),
		.slot_index      (slot_index),
		.page_base       (page_base),
		.in_page_offset  (in_page_offset),
		.reference_count (reference_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic lookup_res_t dir_lookup(lookup_req_t r);
		lookup_res_t       res;
		logic [PAGE_W-1:0] pg;
		int                found;
		pg         = r.off[OFF_W-1:PAGE_SHIFT];
		found      = -1;
		res.hit       = 1'b0;
		res.allocated = 1'b0;
		res.slot      = '0;
		res.refs      = '0;
		res.base      = {pg, {PAGE_SHIFT{1'b0}}};
		res.in_page   = r.off[PAGE_SHIFT-1:0];
		// walk downwards so the lowest matching slot wins
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (slot_used[s] && slot_dev[s] == r.dev && slot_ino[s] == r.ino &&
			    slot_page[s] == pg)
				found = s;
		end
		if (found >= 0) begin
			res.hit  = 1'b1;
			res.slot = found[SLOT_IDX_W-1:0];
			if (r.op == OP_READ && slot_refcnt[found] != REFS_MAX)
				slot_refcnt[found]++;
			res.refs = slot_refcnt[found];
		end else if (r.op == OP_READ) begin
			// victim is overwritten whether or not it still holds a page
			res.allocated          = 1'b1;
			res.slot               = refill_ptr[SLOT_IDX_W-1:0];
			res.refs               = REFS_W'(1);
			slot_used[refill_ptr]   = 1'b1;
			slot_dev[refill_ptr]    = r.dev;
			slot_ino[refill_ptr]    = r.ino;
			slot_page[refill_ptr]   = pg;
			slot_refcnt[refill_ptr] = REFS_W'(1);
			refill_ptr = (refill_ptr + 1) % SLOTS;
		end
		return res;
	endfunction

	function automatic int pick_gap(bit idle_on);
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic queue_lookup(logic op, logic [ID_W-1:0] dev, logic [ID_W-1:0] ino,
	                            logic [OFF_W-1:0] off, bit idle_on, bit drain);
		lookup_req_t w;
		w.op          = op;
		w.dev         = dev;
		w.ino         = ino;
		w.off         = off;
		w.idle_before = pick_gap(idle_on);
		w.drain       = drain;
		w.rx_stall    = idle_on;
		lookup_queue.push_back(w);
	endtask

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	initial begin : stimulus
		logic [ID_W-1:0]   devs  [4];
		logic [ID_W-1:0]   inos  [4];
		logic [PAGE_W-1:0] pages [4];
		bit                idle_on;
		logic              op;
		logic [ID_W-1:0]   dev;
		logic [ID_W-1:0]   ino;
		logic [OFF_W-1:0]  off;

		// empty directory: all-zero tags must not match
		queue_lookup(OP_UPDATE, '0, '0, '0, 1'b1, 1'b0);
		queue_lookup(OP_READ, '0, '0, '0, 1'b1, 1'b0);
		// repeated hits on slot 0, no idling
		for (int i = 0; i < SAT_HITS; i++)
			queue_lookup(OP_READ, '0, '0, {{PAGE_W{1'b0}}, IN_PAGE_W'($urandom)}, 1'b0, 1'b0);
		// sender holds off until every result is back
		queue_lookup(OP_UPDATE, '0, '0, 32'h0000_0FFF, 1'b1, 1'b1);
		queue_lookup(OP_READ, '1, '1, '1, 1'b1, 1'b0);
		queue_lookup(OP_UPDATE, '1, '1, 32'hFFFF_F000, 1'b1, 1'b0);
		queue_lookup(OP_READ, '1, '1, 32'hFFFF_F800, 1'b1, 1'b0);
		// one field off each: device, inode, page
		queue_lookup(OP_UPDATE, 32'hFFFF_FFFE, '1, '1, 1'b1, 1'b0);
		queue_lookup(OP_UPDATE, '1, 32'h7FFF_FFFF, '1, 1'b1, 1'b0);
		queue_lookup(OP_UPDATE, '1, '1, 32'hFFFF_EFFF, 1'b1, 1'b0);
		queue_lookup(OP_READ, '0, '0, 32'h0000_1000, 1'b1, 1'b0);
		queue_lookup(OP_READ, '0, '1, '0, 1'b1, 1'b0);
		queue_lookup(OP_READ, '1, '0, '0, 1'b1, 1'b0);
		queue_lookup(OP_READ, '0, '0, 32'h0000_0ABC, 1'b1, 1'b0);
		queue_lookup(OP_UPDATE, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h1234_5678, 1'b1, 1'b0);

		// small key space, 64 combinations against 32 slots: hits and refills
		for (int i = 0; i < 4; i++) begin
			devs[i]  = $urandom;
			inos[i]  = $urandom;
			pages[i] = PAGE_W'($urandom);
		end
		devs[0]  = '0;
		pages[0] = '0;
		inos[3]  = '1;
		pages[3] = '1;
		idle_on  = 1'b1;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 100 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			op = ($urandom_range(0, 9) < 7) ? OP_READ : OP_UPDATE;
			if ($urandom_range(0, 9) < 8) begin
				dev = devs[$urandom_range(0, 3)];
				ino = inos[$urandom_range(0, 3)];
				off = {pages[$urandom_range(0, 3)], IN_PAGE_W'($urandom)};
			end else begin
				dev = $urandom;
				ino = $urandom;
				off = $urandom;
			end
			queue_lookup(op, dev, ino, off, idle_on, $urandom_range(0, 49) == 0);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (lookup_queue.size() != 0 || in_valid || expected_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	always @(negedge clk) begin : driver
		lookup_req_t w;
		if (arst_n) begin
			if (!in_valid || req_taken) begin
				req_taken = 1'b0;
				if (idle_left > 0) begin
					idle_left--;
					in_valid <= 1'b0;
				end else if (lookup_queue.size() != 0 &&
				             !(lookup_queue[0].drain && expected_lookups.size() != 0)) begin
					w = lookup_queue.pop_front();
					operation    <= w.op;
					device_id    <= w.dev;
					inode_number <= w.ino;
					byte_offset  <= w.off;
					in_valid     <= 1'b1;
					rx_stall_on  = w.rx_stall;
					if (lookup_queue.size() != 0)
						idle_left = lookup_queue[0].idle_before;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (rx_stall_on && $urandom_range(0, 3) == 0)
					stall_left = pick_gap(1'b1);
			end
		end
	end

	always @(posedge clk) begin : monitor
		lookup_req_t w;
		lookup_res_t want;
		if (arst_n) begin
			quiet++;
			// result side first: a result can never belong to this edge's word
			if (out_valid && out_ready) begin
				quiet = 0;
				if (expected_lookups.size() == 0) begin
					mismatches++;
					$display("%0t: result word with nothing outstanding, slot %0h",
					         $time, slot_index);
				end else begin
					want = expected_lookups.pop_front();
					compare_field("hit", want.hit, hit);
					compare_field("allocated", want.allocated, allocated);
					compare_field("slot_index", want.slot, slot_index);
					compare_field("page_base", want.base, page_base);
					compare_field("in_page_offset", want.in_page, in_page_offset);
					compare_field("reference_count", want.refs, reference_count);
				end
			end
			if (in_valid && in_ready) begin
				quiet = 0;
				w.op  = operation;
				w.dev = device_id;
				w.ino = inode_number;
				w.off = byte_offset;
				expected_lookups.push_back(dir_lookup(w));
				req_taken = 1'b1;
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

endmodule
